@@ design/smavg_pkg.sv @@
// Shared types, constants and sizes for the sensor frame moving average block.
`timescale 1ns / 1ps

package smavg_pkg;

   localparam int CHANNELS    = 64;
   localparam int WINDOW      = 50;
   localparam int QUEUE_DEPTH = 2;

   localparam int SAMPLE_W = 8;
   localparam int CFG_W    = 7;
   localparam int AVG_W    = 15;
   localparam int DIFF_W   = 16;
   localparam int CHAN_W   = 6;

   localparam logic [SAMPLE_W-1:0] DELIM = 8'd255;
   localparam int SCALE = 100;

   localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SLOT_W      = $clog2(WINDOW);
   localparam int SUM_MAX     = 255 * WINDOW;
   localparam int SUM_W       = $clog2(SUM_MAX + 1);
   localparam int STORE_DEPTH = CHANNELS * WINDOW;
   localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Ceiling division by WINDOW via an exact reciprocal multiply.
   localparam int NUM_MAX   = SUM_MAX * SCALE + WINDOW - 1;
   localparam int NUM_W     = $clog2(NUM_MAX + 1);
   localparam int DIV_SHIFT = NUM_W + $clog2(WINDOW);
   localparam longint unsigned RECIP =
      ((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
   localparam int RECIP_W   = $clog2(RECIP + 1);
   localparam int PROD_W    = NUM_W + RECIP_W;

   typedef struct packed {
      logic [SAMPLE_W-1:0] rx_byte;
      logic                warmup;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0]        channel;
      logic [SAMPLE_W-1:0]      sample;
      logic [AVG_W-1:0]         average_hundredths;
      logic signed [DIFF_W-1:0] difference_hundredths;
   } rsp_type;

   typedef struct packed {
      logic [CH_W-1:0]     channel;
      logic [SAMPLE_W-1:0] sample;
      logic                warm;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      FP_IDLE    = 2'd0,
      FP_INDEX   = 2'd1,
      FP_READING = 2'd2
   } frame_pos_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ,
      BK_UPDATE,
      BK_DIVIDE,
      BK_RESULT,
      BK_FILL
   } back_state_type;

endpackage

@@ design/smavg_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module smavg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/smavg_front.sv @@
// Frame parser: takes request bytes, holds the channel count and queues completed frames.
`timescale 1ns / 1ps

module smavg_front import smavg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data,
   input  queue_status_type q_status,
   output logic             q_push,
   output job_type          q_job
);

   frame_pos_type       pos_ff, pos_in;
   logic [SAMPLE_W-1:0] pend_ff, pend_in;
   logic [CFG_W-1:0]    active_ff;
   logic                accept;
   logic                in_range;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign in_range  = (9'(pend_ff) < 9'(CHANNELS)) && (9'(pend_ff) < 9'(active_ff));

   always_comb begin
      pos_in         = pos_ff;
      pend_in        = pend_ff;
      q_push         = 1'b0;
      q_job.channel  = pend_ff[CH_W-1:0];
      q_job.sample   = req_data.rx_byte;
      q_job.warm     = req_data.warmup;
      if (accept) begin
         unique case (pos_ff)
            FP_INDEX: begin
               pend_in = req_data.rx_byte;
               pos_in  = FP_READING;
            end
            FP_READING: begin
               pos_in = FP_IDLE;
               q_push = in_range;
            end
            default: begin
               pos_in = FP_IDLE;
            end
         endcase
         if (req_data.rx_byte == DELIM) begin
            pos_in = FP_INDEX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= FP_IDLE;
         pend_ff   <= '0;
         active_ff <= CFG_W'(36);
      end else begin
         pos_ff  <= pos_in;
         pend_ff <= pend_in;
         if (csr_wr_en) begin
            active_ff <= csr_wr_data;
         end
      end
   end

endmodule

@@ design/smavg_queue.sv @@
// Short job queue between the frame parser and the averaging engine.
`timescale 1ns / 1ps

module smavg_queue import smavg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head,
   output queue_status_type status
);

   job_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ design/smavg_back.sv @@
// Averaging engine: window update, rounded-up average, warm-up refill and result register.
`timescale 1ns / 1ps

module smavg_back import smavg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  job_type          q_head,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data
);

   back_state_type      state_ff, state_in;
   job_type             job_ff, job_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [STORE_AW-1:0] addr_ff, addr_in;
   logic [NUM_W-1:0]    num_ff, num_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [SLOT_W-1:0]   fill_ff, fill_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHANNELS-1:0] touched_ff, touched_in;
   logic [CHANNELS-1:0] full_ff, full_in;

   logic                sum_wr_en;
   logic [SUM_W-1:0]    sum_wr_data;
   logic [CH_W-1:0]     sum_rd_addr;
   logic [SUM_W-1:0]    sum_rd_data;
   logic                slot_wr_en;
   logic [SLOT_W-1:0]   slot_wr_data;
   logic [SLOT_W-1:0]   slot_rd_data;
   logic                st_wr_en;
   logic [STORE_AW-1:0] st_wr_addr;
   logic [SAMPLE_W-1:0] st_rd_data;

   logic [STORE_AW-1:0] base;
   logic [SAMPLE_W-1:0] old_sample;
   logic [SUM_W:0]      sum_wide;
   logic [SUM_W-1:0]    new_sum;
   logic [SLOT_W-1:0]   slot_next;
   logic [AVG_W-1:0]    avg;
   logic                out_free;

   assign base       = STORE_AW'(job_ff.channel) * STORE_AW'(WINDOW);
   assign old_sample = full_ff[job_ff.channel] ? st_rd_data : '0;
   assign sum_wide   = (SUM_W + 1)'(sum_ff) - (SUM_W + 1)'(old_sample)
                       + (SUM_W + 1)'(job_ff.sample);
   assign new_sum    = sum_wide[SUM_W-1:0];
   assign slot_next  = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
   assign avg        = prod_ff[DIV_SHIFT +: AVG_W];
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign sum_rd_addr = q_head.channel;

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      sum_in       = sum_ff;
      slot_in      = slot_ff;
      addr_in      = addr_ff;
      num_in       = num_ff;
      prod_in      = prod_ff;
      fill_in      = fill_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      touched_in   = touched_ff;
      full_in      = full_ff;
      q_pop        = 1'b0;
      sum_wr_en    = 1'b0;
      sum_wr_data  = new_sum;
      slot_wr_en   = 1'b0;
      slot_wr_data = slot_next;
      st_wr_en     = 1'b0;
      st_wr_addr   = addr_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               job_in   = q_head;
               state_in = BK_READ;
            end
         end
         BK_READ: begin
            sum_in   = touched_ff[job_ff.channel] ? sum_rd_data : '0;
            slot_in  = touched_ff[job_ff.channel] ? slot_rd_data : '0;
            addr_in  = base + STORE_AW'(slot_in);
            state_in = BK_UPDATE;
         end
         BK_UPDATE: begin
            st_wr_en   = 1'b1;
            sum_wr_en  = 1'b1;
            slot_wr_en = 1'b1;
            touched_in[job_ff.channel] = 1'b1;
            if (slot_ff == SLOT_W'(WINDOW - 1)) begin
               full_in[job_ff.channel] = 1'b1;
            end
            num_in   = NUM_W'(new_sum) * NUM_W'(SCALE) + NUM_W'(WINDOW - 1);
            state_in = BK_DIVIDE;
         end
         BK_DIVIDE: begin
            prod_in  = PROD_W'(num_ff) * PROD_W'(RECIP);
            state_in = BK_RESULT;
         end
         BK_RESULT: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_in.channel            = CHAN_W'(job_ff.channel);
               rsp_in.sample             = job_ff.sample;
               rsp_in.average_hundredths = avg;
               rsp_in.difference_hundredths =
                  $signed(DIFF_W'(avg) - DIFF_W'(DIFF_W'(job_ff.sample) * DIFF_W'(SCALE)));
               if (job_ff.warm) begin
                  sum_wr_en   = 1'b1;
                  sum_wr_data = SUM_W'(SUM_W'(job_ff.sample) * SUM_W'(WINDOW));
                  full_in[job_ff.channel] = 1'b1;
                  fill_in     = '0;
                  state_in    = BK_FILL;
               end else begin
                  state_in = BK_IDLE;
               end
            end
         end
         BK_FILL: begin
            st_wr_en   = 1'b1;
            st_wr_addr = base + STORE_AW'(fill_ff);
            fill_in    = fill_ff + 1'b1;
            if (fill_ff == SLOT_W'(WINDOW - 1)) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      sum_ff  <= sum_in;
      slot_ff <= slot_in;
      addr_ff <= addr_in;
      num_ff  <= num_in;
      prod_ff <= prod_in;
      fill_ff <= fill_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         touched_ff   <= '0;
         full_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         touched_ff   <= touched_in;
         full_ff      <= full_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   smavg_ram #(.WIDTH(SUM_W), .DEPTH(CHANNELS)) u_sum_ram (
      .clock   (clock),
      .wr_en   (sum_wr_en),
      .wr_addr (job_ff.channel),
      .wr_data (sum_wr_data),
      .rd_addr (sum_rd_addr),
      .rd_data (sum_rd_data)
   );

   smavg_ram #(.WIDTH(SLOT_W), .DEPTH(CHANNELS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (job_ff.channel),
      .wr_data (slot_wr_data),
      .rd_addr (sum_rd_addr),
      .rd_data (slot_rd_data)
   );

   smavg_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_DEPTH)) u_store_ram (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (job_ff.sample),
      .rd_addr (addr_in),
      .rd_data (st_rd_data)
   );

   a_fill_only_warm: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_FILL) |-> job_ff.warm)
      else $error("refill running for a request without warm-up");

   a_slot_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_UPDATE) |-> (slot_ff < SLOT_W'(WINDOW)))
      else $error("oldest slot outside the window");

   a_sum_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_UPDATE) |-> (sum_wide <= (SUM_W + 1)'(SUM_MAX)))
      else $error("window sum out of range");

   a_result_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_RESULT && state_in != BK_RESULT) |-> out_free)
      else $error("result overwritten before it was taken");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (!q_status.empty && state_ff == BK_IDLE))
      else $error("pop from an empty queue or while busy");

endmodule

@@ design/sensor_frame_moving_average_top.sv @@
// Top level of the per-channel moving average over framed sensor bytes.
`timescale 1ns / 1ps

// Each request is one serial byte; a frame is the delimiter 255, a channel index and a
// reading, and a frame for an active channel gives one response with the channel, the
// reading, the window average in hundredths rounded up, and average minus reading. The
// parser takes one request per cycle while its two-entry job queue has room. The engine
// takes one frame at a time through its steps (memory read, window update, reciprocal
// multiply, result, held while the response is not taken), and adds a refill when the
// frame carries warm-up, which writes the window store one slot per cycle through its
// single write port; the queue holds further frames while the engine is busy. Windows
// start as zero after reset through per-channel valid bits, so there is no clearing pass.
// csr_wr_data sets the number of active channels; write it only while the block is idle.
module sensor_frame_moving_average_top import smavg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data
);

   queue_status_type q_status;
   logic             q_push;
   logic             q_pop;
   job_type          q_job;
   job_type          q_head;

   smavg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_job       (q_job)
   );

   smavg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .pop      (q_pop),
      .head     (q_head),
      .status   (q_status)
   );

   smavg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
